@@ src/rhht_pkg.sv @@
// Package with types, constants and hash functions for the Robin Hood hash table.
`default_nettype none
package rhht_pkg;
  localparam int unsigned TableSize = 1024;
  localparam int unsigned IdxW = $clog2(TableSize);
  localparam logic [31:0] HashMul = 32'h045d9f3b;
  localparam logic [9:0] LoadLimitReset = 10'd819;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_INVALID = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD_VALUE = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [31:0] key_a;
    logic [31:0] key_b;
    logic [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] found_value;
  } out_item_t;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [31:0] key_a;
    logic [31:0] key_b;
    logic [31:0] value;
    logic [IdxW-1:0] disp;
  } slot_t;

  // Arithmetic shift right by 16, xored with the word.
  function automatic logic [31:0] shift_xor(input logic [31:0] x);
    shift_xor = x ^ {{16{x[31]}}, x[31:16]};
  endfunction
endpackage
`default_nettype wire

@@ src/robin_hood_hash_table_unit.sv @@
// Top level: Robin Hood hash table, one probe slot per step.
// Steps: hash the keys, read and check the home slot, then each further slot in turn;
// a remove then shifts the following entries back, and the result waits for the output.
// One item at a time: a new item is accepted only in S_IDLE, once the last one is handed on.
// Reset: synchronous rst_n restores counters and load limit; a pass over all 1024 slots then clears
// the occupied flags while the input is held off.
`default_nettype none
module robin_hood_hash_table_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire rhht_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output rhht_pkg::out_item_t out_data,
  input  wire logic cfg_we,
  input  wire logic [9:0] cfg_wdata
);
  localparam int unsigned W = rhht_pkg::IdxW;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_HASH = 7'b0000010,
    S_RD   = 7'b0000100,
    S_EVAL = 7'b0001000,
    S_RRD  = 7'b0010000,
    S_REVL = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  rhht_pkg::in_item_t item_r, item_nxt;
  rhht_pkg::out_item_t res_r, res_nxt;
  rhht_pkg::out_item_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [9:0] limit_r, limit_nxt;
  logic [W:0] maxd_r, maxd_nxt;
  logic [W-1:0] count_r, count_nxt;
  logic [1:0] hcnt_r, hcnt_nxt;
  logic [W-1:0] idx_r, idx_nxt;
  logic [W:0] d_r, d_nxt;
  rhht_pkg::slot_t carry_r, carry_nxt;

  logic [W-1:0] home;
  rhht_pkg::slot_t rd_data, wr_data;
  logic rd_occ, wr_en, occ_en, occ_val, mem_busy;
  logic [W-1:0] wr_addr, rd_addr, occ_addr;

  rhht_hash u_hash (
    .clk(clk), .key_a(item_r.key_a), .key_b(item_r.key_b), .home(home)
  );

  rhht_mem u_mem (
    .clk(clk), .rst_n(rst_n), .rd_addr(rd_addr), .rd_data(rd_data), .rd_occ(rd_occ),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .occ_en(occ_en), .occ_addr(occ_addr), .occ_val(occ_val), .busy(mem_busy)
  );

  assign in_ready = (state_r == S_IDLE) && !mem_busy;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  logic [W-1:0] idx_inc;
  logic key_hit, cnt_full;
  assign idx_inc = idx_r + 1'b1;
  assign key_hit = (rd_data.key_a == item_r.key_a) && (rd_data.key_b == item_r.key_b);
  assign cnt_full = ({1'b0, count_r} > {{(W-9){1'b0}}, limit_r})
                    || ({1'b0, count_r} + 1'b1 >= (W+1)'(rhht_pkg::TableSize));

  // During removal the read address runs one slot ahead of the hole.
  always_comb begin
    case (state_r)
      S_HASH: rd_addr = home;
      S_RRD: rd_addr = idx_inc;
      default: rd_addr = idx_r;
    endcase
  end

  // Control: hash, then walk the probe chain one slot at a time.
  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    res_nxt = res_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    limit_nxt = limit_r;
    maxd_nxt = maxd_r;
    count_nxt = count_r;
    hcnt_nxt = hcnt_r;
    idx_nxt = idx_r;
    d_nxt = d_r;
    carry_nxt = carry_r;
    wr_en = 1'b0;
    wr_addr = idx_r;
    wr_data = carry_r;
    occ_en = 1'b0;
    occ_addr = idx_r;
    occ_val = 1'b0;
    if (cfg_we) begin
      limit_nxt = cfg_wdata;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          item_nxt = in_data;
          hcnt_nxt = '0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        hcnt_nxt = hcnt_r + 1'b1;
        if (hcnt_r == 2'd2) begin
          idx_nxt = home;
          d_nxt = '0;
          carry_nxt = '{item_r.key_a, item_r.key_b, item_r.entry_value, {W{1'b0}}};
          res_nxt = '{rhht_pkg::ST_NOT_FOUND, 32'd0};
          state_nxt = S_EVAL;
          if (item_r.operation == rhht_pkg::OP_INSERT) begin
            if (item_r.entry_value == 32'd0) begin
              res_nxt.status = rhht_pkg::ST_BAD_VALUE;
              state_nxt = S_DONE;
            end else if (cnt_full) begin
              res_nxt.status = rhht_pkg::ST_FULL;
              state_nxt = S_DONE;
            end
          end else if (item_r.operation != rhht_pkg::OP_FIND
                       && item_r.operation != rhht_pkg::OP_REMOVE) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_RD;
        idx_nxt = idx_inc;
        d_nxt = d_r + 1'b1;
        if (item_r.operation == rhht_pkg::OP_INSERT) begin
          if (!rd_occ) begin
            wr_en = 1'b1;
            wr_data = '{carry_r.key_a, carry_r.key_b, carry_r.value, d_r[W-1:0]};
            occ_en = 1'b1;
            occ_val = 1'b1;
            if (maxd_r < d_r + 1'b1) maxd_nxt = d_r + 1'b1;
            count_nxt = count_r + 1'b1;
            res_nxt.status = rhht_pkg::ST_OK;
            state_nxt = S_DONE;
          end else if ({1'b0, rd_data.disp} < d_r) begin
            wr_en = 1'b1;
            wr_data = '{carry_r.key_a, carry_r.key_b, carry_r.value, d_r[W-1:0]};
            if (maxd_r < d_r + 1'b1) maxd_nxt = d_r + 1'b1;
            carry_nxt = rd_data;
            d_nxt = {1'b0, rd_data.disp} + 1'b1;
          end
        end else begin
          if (d_r >= maxd_r || !rd_occ) begin
            state_nxt = S_DONE;
          end else if (key_hit) begin
            res_nxt.status = rhht_pkg::ST_OK;
            if (item_r.operation == rhht_pkg::OP_FIND) begin
              res_nxt.found_value = rd_data.value;
              state_nxt = S_DONE;
            end else begin
              // Remove: hole at idx_r, shift successors back.
              idx_nxt = idx_r;
              state_nxt = S_RRD;
            end
          end
        end
      end
      S_RRD: begin
        state_nxt = S_REVL;
      end
      S_REVL: begin
        // rd_data holds the slot after the hole at idx_r.
        if (rd_occ && rd_data.disp != '0) begin
          wr_en = 1'b1;
          wr_data = '{rd_data.key_a, rd_data.key_b, rd_data.value, rd_data.disp - 1'b1};
          idx_nxt = idx_inc;
          state_nxt = S_RRD;
        end else begin
          occ_en = 1'b1;
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_ready) begin
          out_nxt = res_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      limit_r <= rhht_pkg::LoadLimitReset;
      maxd_r <= '0;
      count_r <= '0;
      hcnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      limit_r <= limit_nxt;
      maxd_r <= maxd_nxt;
      count_r <= count_nxt;
      hcnt_r <= hcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
    idx_r <= idx_nxt;
    d_r <= d_nxt;
    carry_r <= carry_nxt;
  end
endmodule
`default_nettype wire

@@ src/rhht_hash.sv @@
// Pipelined hash of the two key words down to a home slot index.
`default_nettype none
module rhht_hash (
  input  wire logic clk,
  input  wire logic [31:0] key_a,
  input  wire logic [31:0] key_b,
  output logic [rhht_pkg::IdxW-1:0] home
);
  logic [31:0] m1a_r, m1b_r, m2a_r, m2b_r;
  logic [31:0] m1a_nxt, m1b_nxt, m2a_nxt, m2b_nxt;

  // First round, then second round, each behind a register.
  assign m1a_nxt = rhht_pkg::shift_xor(key_a) * rhht_pkg::HashMul;
  assign m1b_nxt = rhht_pkg::shift_xor(key_b) * rhht_pkg::HashMul;
  assign m2a_nxt = rhht_pkg::shift_xor(m1a_r) * rhht_pkg::HashMul;
  assign m2b_nxt = rhht_pkg::shift_xor(m1b_r) * rhht_pkg::HashMul;

  always_ff @(posedge clk) begin
    m1a_r <= m1a_nxt;
    m1b_r <= m1b_nxt;
    m2a_r <= m2a_nxt;
    m2b_r <= m2b_nxt;
  end

  logic [31:0] fin;
  assign fin = rhht_pkg::shift_xor(m2a_r) ^ rhht_pkg::shift_xor(m2b_r);
  assign home = fin[rhht_pkg::IdxW-1:0];
endmodule
`default_nettype wire

@@ src/rhht_mem.sv @@
// Slot memory and occupied-flag memory, with a clearing pass over the flags after reset.
`default_nettype none
module rhht_mem (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [rhht_pkg::IdxW-1:0] rd_addr,
  output rhht_pkg::slot_t rd_data,
  output logic rd_occ,
  input  wire logic wr_en,
  input  wire logic [rhht_pkg::IdxW-1:0] wr_addr,
  input  wire rhht_pkg::slot_t wr_data,
  input  wire logic occ_en,
  input  wire logic [rhht_pkg::IdxW-1:0] occ_addr,
  input  wire logic occ_val,
  output logic busy
);
  rhht_pkg::slot_t mem [rhht_pkg::TableSize];
  logic occ_mem [rhht_pkg::TableSize];
  logic clr_busy_r, clr_busy_nxt;
  logic [rhht_pkg::IdxW-1:0] clr_idx_r, clr_idx_nxt;

  assign busy = clr_busy_r;

  // Synchronous data array, one read and one write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Clearing pass: one flag per cycle from slot 0 to the last slot.
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt = clr_idx_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (&clr_idx_r) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // Occupied flags, written by the clearing pass or by the control.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      occ_mem[clr_idx_r] <= 1'b0;
    end else if (occ_en) begin
      occ_mem[occ_addr] <= occ_val;
    end
    rd_occ <= occ_mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ dv/tb_robin_hood_hash_table_unit.sv @@
// Testbench for the Robin Hood hash table unit: random and directed operations checked against a model.
module tb_robin_hood_hash_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = 1024;
  localparam int unsigned StallLimit = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  rhht_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  rhht_pkg::out_item_t out_data;
  logic cfg_we;
  logic [9:0] cfg_wdata;

  robin_hood_hash_table_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Model of the table contents.
  logic [31:0] tbl_ka [Slots];
  logic [31:0] tbl_kb [Slots];
  logic [31:0] tbl_val [Slots];
  int unsigned tbl_disp [Slots];
  bit tbl_used [Slots];
  int unsigned probe_bound;
  int unsigned stored;
  logic [9:0] limit_reg;

  // Keys drawn for random items, reused to make finds and removes hit.
  logic [31:0] known_ka [$];
  logic [31:0] known_kb [$];

  rhht_pkg::in_item_t pending_items [$];
  rhht_pkg::out_item_t expected_results [$];

  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_recv;
  int hold_cycles;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] mix_word(input logic [31:0] x);
    logic [31:0] y;
    y = (x ^ {{16{x[31]}}, x[31:16]}) * 32'h045d9f3b;
    y = (y ^ {{16{y[31]}}, y[31:16]}) * 32'h045d9f3b;
    return y ^ {{16{y[31]}}, y[31:16]};
  endfunction

  function automatic int unsigned home_of(input logic [31:0] ka, input logic [31:0] kb);
    logic [31:0] h;
    h = mix_word(ka) ^ mix_word(kb);
    return h % Slots;
  endfunction

  function automatic bit lookup_slot(input logic [31:0] ka, input logic [31:0] kb,
                                     output int unsigned where);
    int unsigned idx;
    idx = home_of(ka, kb);
    where = 0;
    for (int unsigned d = 0; d < probe_bound && d < Slots; d++) begin
      if (!tbl_used[idx]) return 1'b0;
      if (tbl_ka[idx] == ka && tbl_kb[idx] == kb) begin
        where = idx;
        return 1'b1;
      end
      idx = (idx + 1) % Slots;
    end
    return 1'b0;
  endfunction

  function automatic void place_entry(input logic [31:0] ka_in, input logic [31:0] kb_in,
                                      input logic [31:0] v_in);
    int unsigned idx;
    int unsigned d;
    int unsigned td;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] v;
    logic [31:0] ta;
    logic [31:0] tb;
    logic [31:0] tv;
    ka = ka_in;
    kb = kb_in;
    v = v_in;
    idx = home_of(ka, kb);
    d = 0;
    while (tbl_used[idx]) begin
      if (tbl_disp[idx] < d) begin
        ta = tbl_ka[idx]; tb = tbl_kb[idx]; tv = tbl_val[idx]; td = tbl_disp[idx];
        tbl_ka[idx] = ka; tbl_kb[idx] = kb; tbl_val[idx] = v; tbl_disp[idx] = d;
        if (probe_bound < d + 1) probe_bound = d + 1;
        ka = ta; kb = tb; v = tv; d = td;
      end
      idx = (idx + 1) % Slots;
      d++;
    end
    tbl_ka[idx] = ka; tbl_kb[idx] = kb; tbl_val[idx] = v; tbl_disp[idx] = d;
    tbl_used[idx] = 1'b1;
    if (probe_bound < d + 1) probe_bound = d + 1;
    stored++;
  endfunction

  function automatic void shift_back(input int unsigned at);
    int unsigned idx;
    int unsigned nx;
    idx = at;
    nx = (idx + 1) % Slots;
    while (tbl_used[nx] && tbl_disp[nx] != 0) begin
      tbl_ka[idx] = tbl_ka[nx]; tbl_kb[idx] = tbl_kb[nx];
      tbl_val[idx] = tbl_val[nx]; tbl_disp[idx] = tbl_disp[nx] - 1;
      idx = nx;
      nx = (nx + 1) % Slots;
    end
    tbl_used[idx] = 1'b0;
    stored--;
  endfunction

  // Computes the result of one accepted item and updates the table model.
  function automatic rhht_pkg::out_item_t table_result(input rhht_pkg::in_item_t it);
    rhht_pkg::out_item_t r;
    int unsigned where;
    r.status = rhht_pkg::ST_NOT_FOUND;
    r.found_value = '0;
    case (it.operation)
      rhht_pkg::OP_INSERT: begin
        if (it.entry_value == 0) r.status = rhht_pkg::ST_BAD_VALUE;
        else if (stored > limit_reg || stored + 1 >= Slots) r.status = rhht_pkg::ST_FULL;
        else begin
          place_entry(it.key_a, it.key_b, it.entry_value);
          r.status = rhht_pkg::ST_OK;
        end
      end
      rhht_pkg::OP_FIND: begin
        if (lookup_slot(it.key_a, it.key_b, where)) begin
          r.status = rhht_pkg::ST_OK;
          r.found_value = tbl_val[where];
        end
      end
      rhht_pkg::OP_REMOVE: begin
        if (lookup_slot(it.key_a, it.key_b, where)) begin
          shift_back(where);
          r.status = rhht_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: offers items from the queue, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_results.push_back(table_result(in_data));
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver readiness, with an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_recv) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compares each result with the oldest expectation.
  always @(posedge clk) begin
    rhht_pkg::out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h", $time,
                 out_data.status, out_data.found_value);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.status !== out_data.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   out_data.status);
          errors++;
        end
        if (exp_r.found_value !== out_data.found_value) begin
          $display("%0t: found_value expected %h actual %h", $time,
                   exp_r.found_value, out_data.found_value);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item or taken result.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic rhht_pkg::in_item_t make_item(input logic [1:0] op,
                                                   input logic [31:0] ka,
                                                   input logic [31:0] kb,
                                                   input logic [31:0] v);
    rhht_pkg::in_item_t it;
    it.operation = op;
    it.key_a = ka;
    it.key_b = kb;
    it.entry_value = v;
    return it;
  endfunction

  // Random item: mostly operations on a small key pool so finds and removes hit.
  function automatic rhht_pkg::in_item_t random_item();
    logic [1:0] op;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] v;
    int unsigned pick;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) op = rhht_pkg::OP_INSERT;
    else if (r < 75) op = rhht_pkg::OP_FIND;
    else if (r < 97) op = rhht_pkg::OP_REMOVE;
    else op = rhht_pkg::OP_INVALID;
    if (known_ka.size() > 0 && $urandom_range(99) < 60) begin
      pick = $urandom_range(known_ka.size() - 1);
      ka = known_ka[pick];
      kb = known_kb[pick];
    end else begin
      ka = $urandom();
      kb = $urandom();
      if ($urandom_range(9) == 0) ka = {ka[31:8], 8'h00};
      if (known_ka.size() < 300) begin
        known_ka.push_back(ka);
        known_kb.push_back(kb);
      end
    end
    v = $urandom();
    if ($urandom_range(39) == 0) v = '0;
    return make_item(op, ka, kb, v);
  endfunction

  // Waits until every queued item is accepted and every result has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_limit(input logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_reg = val;
  endtask

  // Queues inserts of random keys with nonzero values.
  task automatic fill_phase(input int n);
    for (int i = 0; i < n; i++)
      pending_items.push_back(make_item(rhht_pkg::OP_INSERT, $urandom(), $urandom(),
                                        $urandom() | 1));
  endtask

  initial begin
    rhht_pkg::in_item_t it;
    errors = 0;
    send_idle_pct = 30;
    recv_idle_pct = 76;
    hold_recv = 1'b0;
    hold_cycles = 0;
    quiet_cycles = 0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    probe_bound = 0;
    stored = 0;
    limit_reg = rhht_pkg::LoadLimitReset;
    for (int i = 0; i < Slots; i++) tbl_used[i] = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every operation, zero value, duplicates, absent keys.
    pending_items.push_back(make_item(rhht_pkg::OP_FIND, 32'h0, 32'h0, 32'h0));
    pending_items.push_back(make_item(rhht_pkg::OP_REMOVE, 32'h0, 32'h0, 32'h0));
    pending_items.push_back(make_item(rhht_pkg::OP_INSERT, 32'h0, 32'h0, 32'h0));
    pending_items.push_back(make_item(rhht_pkg::OP_INSERT, 32'h0, 32'h0, 32'hffffffff));
    pending_items.push_back(make_item(rhht_pkg::OP_INSERT, 32'hffffffff, 32'hffffffff,
                                      32'h1));
    pending_items.push_back(make_item(rhht_pkg::OP_INSERT, 32'h0, 32'h0, 32'h12345678));
    pending_items.push_back(make_item(rhht_pkg::OP_FIND, 32'h0, 32'h0, 32'h0));
    pending_items.push_back(make_item(rhht_pkg::OP_FIND, 32'hffffffff, 32'hffffffff,
                                      32'hffffffff));
    pending_items.push_back(make_item(rhht_pkg::OP_INSERT, 32'h80000000, 32'h7fffffff,
                                      32'haaaa5555));
    pending_items.push_back(make_item(rhht_pkg::OP_INSERT, 32'h7fffffff, 32'h80000000,
                                      32'h5555aaaa));
    pending_items.push_back(make_item(rhht_pkg::OP_INVALID, 32'h0, 32'h0, 32'h1));
    pending_items.push_back(make_item(rhht_pkg::OP_REMOVE, 32'h0, 32'h0, 32'h0));
    pending_items.push_back(make_item(rhht_pkg::OP_FIND, 32'h0, 32'h0, 32'h0));
    pending_items.push_back(make_item(rhht_pkg::OP_REMOVE, 32'h0, 32'h0, 32'h0));
    pending_items.push_back(make_item(rhht_pkg::OP_REMOVE, 32'h0, 32'h0, 32'h0));
    pending_items.push_back(make_item(rhht_pkg::OP_FIND, 32'h80000000, 32'h7fffffff,
                                      32'h0));
    pending_items.push_back(make_item(rhht_pkg::OP_REMOVE, 32'hffffffff, 32'hffffffff,
                                      32'h0));
    wait_drained();

    // Small limits: table_full reached quickly.
    set_limit(10'd0);
    fill_phase(3);
    wait_drained();
    set_limit(10'd5);
    fill_phase(8);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering items.
    for (int i = 0; i < 40; i++) pending_items.push_back(random_item());
    hold_recv = 1'b1;
    while (hold_cycles < 300) @(posedge clk);
    hold_recv = 1'b0;
    wait_drained();

    // Random phases with different idling.
    set_limit(rhht_pkg::LoadLimitReset);
    for (int i = 0; i < 300; i++) pending_items.push_back(random_item());
    wait_drained();
    send_idle_pct = 76;
    recv_idle_pct = 30;
    for (int i = 0; i < 300; i++) pending_items.push_back(random_item());
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 250; i++) pending_items.push_back(random_item());
    wait_drained();

    // High limit: fill close to full so the one-empty-slot rule applies.
    set_limit(10'd1022);
    fill_phase(1030);
    for (int i = 0; i < 100; i++) begin
      it = random_item();
      pending_items.push_back(it);
    end
    wait_drained();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ sim.f @@
src/rhht_pkg.sv
src/rhht_hash.sv
src/rhht_mem.sv
src/robin_hood_hash_table_unit.sv
dv/tb_robin_hood_hash_table_unit.sv
